@@ sv/swco_pkg.sv @@
// ----------------------------------------------------------------------------
// swco_pkg: shared types and constants for stamp window clipping
// Widths of the position, step and size fields and the structs that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none
package swco_pkg;

   localparam int POS_W  = 32;
   localparam int STEP_W = 31;
   localparam int DIM_W  = 13;
   localparam int OFS_W  = 24;
   localparam int Z_W    = POS_W + 2;
   localparam int EXT_W  = DIM_W + STEP_W;
   localparam int NUM_W  = EXT_W + 1;
   localparam int CMP_W  = NUM_W + 1;
   localparam int DIV_W  = STEP_W + 1;
   localparam int Q_W    = DIM_W;
   localparam int LANES  = 4;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_INSIDE = 2'd1,
      KIND_BEFORE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_ORG_X  = 3'd0,
      REG_ORG_Y  = 3'd1,
      REG_STEP_X = 3'd2,
      REG_STEP_Y = 3'd3,
      REG_IMG_C  = 3'd4,
      REG_IMG_R  = 3'd5,
      REG_STP_C  = 3'd6,
      REG_STP_R  = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] org_x;
      logic signed [POS_W-1:0] org_y;
      logic [STEP_W-1:0]       step_x;
      logic [STEP_W-1:0]       step_y;
      logic [DIM_W-1:0]        img_c;
      logic [DIM_W-1:0]        img_r;
      logic [DIM_W-1:0]        stp_c;
      logic [DIM_W-1:0]        stp_r;
   } cfg_type;

   typedef struct packed {
      kind_type kind_x;
      kind_type kind_y;
   } side_type;

   typedef struct packed {
      logic [OFS_W-1:0] image_offset;
      logic [OFS_W-1:0] stamp_offset;
      logic [DIM_W-1:0] overlap_cols;
      logic [DIM_W-1:0] overlap_rows;
   } res_type;

endpackage
`default_nettype wire

@@ sv/swco_req_if.sv @@
// ----------------------------------------------------------------------------
// swco_req_if: position channel
// Carries one point position per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface swco_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [swco_pkg::POS_W-1:0] pos_x;
   logic signed [swco_pkg::POS_W-1:0] pos_y;

   modport source (output valid, output pos_x, output pos_y, input ready);
   modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

@@ sv/swco_rsp_if.sv @@
// ----------------------------------------------------------------------------
// swco_rsp_if: clipping result channel
// Carries the offsets and overlap size of one position per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface swco_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [swco_pkg::OFS_W-1:0] image_offset;
   logic [swco_pkg::OFS_W-1:0] stamp_offset;
   logic [swco_pkg::DIM_W-1:0] overlap_cols;
   logic [swco_pkg::DIM_W-1:0] overlap_rows;

   modport source (output valid, output image_offset, output stamp_offset,
                   output overlap_cols, output overlap_rows, input ready);
   modport sink (input valid, input image_offset, input stamp_offset,
                 input overlap_cols, input overlap_rows, output ready);
endinterface
`default_nettype wire

@@ sv/stamp_window_clip_offsets.sv @@
// ----------------------------------------------------------------------------
// stamp_window_clip_offsets: overlap of a centered stamp with an image
// A position passes through seventeen register stages from the edge that accepts
// it to the edge at which its result can be taken: two front-end stages,
// thirteen divider stages (one quotient bit each) and two output stages.
// Throughput is one transaction per cycle; the whole pipeline holds when the
// result register is full and not taken. Reset clears all valid bits and loads
// the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module stamp_window_clip_offsets #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   swco_req_if.sink         req,
   swco_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int DW = swco_pkg::DIM_W;
   localparam logic [DW-1:0] DIM_LIM =
      DW'((MAX_DIM > (2**DW - 1)) ? (2**DW - 1) : MAX_DIM);
   localparam logic [swco_pkg::STEP_W-1:0] STEP_RST =
      swco_pkg::STEP_W'(64'd1 << FRAC_BITS);

   swco_pkg::cfg_type     cfg_ff;
   swco_pkg::reg_idx_type idx;
   logic                  wr, adv;
   logic                  pv, dv, ov;
   logic [swco_pkg::LANES-1:0][swco_pkg::NUM_W-1:0] num;
   logic [swco_pkg::LANES-1:0][swco_pkg::Q_W-1:0]   quo;
   swco_pkg::side_type    ps, ds;
   swco_pkg::res_type     res;
   logic [DW-1:0]         dim_w;
   logic [swco_pkg::STEP_W-1:0] step_w;

   assign idx    = swco_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr     = csr_psel && csr_penable && csr_pwrite;
   assign dim_w  = (csr_pwdata[DW-1:0] > DIM_LIM) ? DIM_LIM : csr_pwdata[DW-1:0];
   assign step_w = (csr_pwdata[swco_pkg::STEP_W-1:0] == '0)
                 ? swco_pkg::STEP_W'(1) : csr_pwdata[swco_pkg::STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.org_x  <= '0;
         cfg_ff.org_y  <= '0;
         cfg_ff.step_x <= STEP_RST;
         cfg_ff.step_y <= STEP_RST;
         cfg_ff.img_c  <= DW'(64);
         cfg_ff.img_r  <= DW'(64);
         cfg_ff.stp_c  <= DW'(50);
         cfg_ff.stp_r  <= DW'(50);
      end else if (wr) begin
         case (idx)
            swco_pkg::REG_ORG_X:  cfg_ff.org_x  <= $signed(csr_pwdata);
            swco_pkg::REG_ORG_Y:  cfg_ff.org_y  <= $signed(csr_pwdata);
            swco_pkg::REG_STEP_X: cfg_ff.step_x <= step_w;
            swco_pkg::REG_STEP_Y: cfg_ff.step_y <= step_w;
            swco_pkg::REG_IMG_C:  cfg_ff.img_c  <= dim_w;
            swco_pkg::REG_IMG_R:  cfg_ff.img_r  <= dim_w;
            swco_pkg::REG_STP_C:  cfg_ff.stp_c  <= dim_w;
            swco_pkg::REG_STP_R:  cfg_ff.stp_r  <= dim_w;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         swco_pkg::REG_ORG_X:  csr_prdata = cfg_ff.org_x;
         swco_pkg::REG_ORG_Y:  csr_prdata = cfg_ff.org_y;
         swco_pkg::REG_STEP_X: csr_prdata = {1'b0, cfg_ff.step_x};
         swco_pkg::REG_STEP_Y: csr_prdata = {1'b0, cfg_ff.step_y};
         swco_pkg::REG_IMG_C:  csr_prdata = {{(32-DW){1'b0}}, cfg_ff.img_c};
         swco_pkg::REG_IMG_R:  csr_prdata = {{(32-DW){1'b0}}, cfg_ff.img_r};
         swco_pkg::REG_STP_C:  csr_prdata = {{(32-DW){1'b0}}, cfg_ff.stp_c};
         swco_pkg::REG_STP_R:  csr_prdata = {{(32-DW){1'b0}}, cfg_ff.stp_r};
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign adv       = !ov || rsp.ready;
   assign req.ready = adv;

   swco_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .pos_x     (req.pos_x),
      .pos_y     (req.pos_y),
      .cfg       (cfg_ff),
      .out_valid (pv),
      .num       (num),
      .side      (ps)
   );

   swco_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pv),
      .num       (num),
      .in_side   (ps),
      .step_x    (cfg_ff.step_x),
      .step_y    (cfg_ff.step_y),
      .out_valid (dv),
      .quo       (quo),
      .out_side  (ds)
   );

   swco_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv),
      .quo       (quo),
      .side      (ds),
      .cfg       (cfg_ff),
      .out_valid (ov),
      .res       (res)
   );

   assign rsp.valid        = ov;
   assign rsp.image_offset = res.image_offset;
   assign rsp.stamp_offset = res.stamp_offset;
   assign rsp.overlap_cols = res.overlap_cols;
   assign rsp.overlap_rows = res.overlap_rows;

   a_zero_all: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.overlap_cols == '0) |->
         (rsp.overlap_rows == '0) && (rsp.image_offset == '0)
         && (rsp.stamp_offset == '0))
      else $error("partial result on a transaction without overlap");

   a_cols_fit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.overlap_cols <= cfg_ff.img_c)
                 && (rsp.overlap_rows <= cfg_ff.img_r))
      else $error("overlap exceeds the image size");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("position taken while the result is stalled");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(res))
      else $error("stalled result changed");

endmodule
`default_nettype wire

@@ sv/swco_prep.sv @@
// ----------------------------------------------------------------------------
// swco_prep: offset and extent front end
// Forms doubled offsets and stamp extents, classifies each axis and builds
// the dividends for the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module swco_prep (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   adv,
   input  wire logic                                   in_valid,
   input  wire logic signed [swco_pkg::POS_W-1:0]      pos_x,
   input  wire logic signed [swco_pkg::POS_W-1:0]      pos_y,
   input  wire swco_pkg::cfg_type                      cfg,
   output logic                                        out_valid,
   output logic [swco_pkg::LANES-1:0][swco_pkg::NUM_W-1:0] num,
   output swco_pkg::side_type                          side
);

   logic                                 v1_ff, v1_in;
   logic signed [swco_pkg::Z_W-1:0]      zx_ff, zx_in, zy_ff, zy_in;
   logic [swco_pkg::EXT_W-1:0]           wx_ff, wx_in, wy_ff, wy_in;
   logic signed [swco_pkg::POS_W:0]      dx, dy;
   logic                                 v2_ff;
   logic [swco_pkg::LANES-1:0][swco_pkg::NUM_W-1:0] num_ff, num_in;
   swco_pkg::side_type                   side_ff, side_in;
   swco_pkg::kind_type                   kx, ky;
   logic [swco_pkg::NUM_W-1:0]           xa, xb, ya, yb;

   function automatic void classify(
      input  logic signed [swco_pkg::Z_W-1:0] z,
      input  logic [swco_pkg::EXT_W-1:0]      w,
      output swco_pkg::kind_type              kind,
      output logic [swco_pkg::NUM_W-1:0]      na,
      output logic [swco_pkg::NUM_W-1:0]      nb
   );
      logic signed [swco_pkg::CMP_W-1:0] sz;
      logic signed [swco_pkg::CMP_W-1:0] sw;
      logic signed [swco_pkg::CMP_W-1:0] t;
      sz = swco_pkg::CMP_W'(z);
      sw = $signed({{(swco_pkg::CMP_W-swco_pkg::EXT_W){1'b0}}, w});
      if ((-sw < sz) && (sz < sw)) begin
         kind = swco_pkg::KIND_INSIDE;
         t    = sz + sw;
      end else if (sz < -sw) begin
         kind = swco_pkg::KIND_BEFORE;
         t    = -sw - sz;
      end else begin
         kind = swco_pkg::KIND_NONE;
         t    = '0;
      end
      na = t[swco_pkg::NUM_W-1:0];
      t  = sw - sz;
      nb = t[swco_pkg::NUM_W-1:0];
   endfunction

   always_comb begin
      v1_in = in_valid;
      dx    = $signed({cfg.org_x[swco_pkg::POS_W-1], cfg.org_x})
            - $signed({pos_x[swco_pkg::POS_W-1], pos_x});
      dy    = $signed({cfg.org_y[swco_pkg::POS_W-1], cfg.org_y})
            - $signed({pos_y[swco_pkg::POS_W-1], pos_y});
      zx_in = $signed({dx, 1'b0});
      zy_in = $signed({dy, 1'b0});
      wx_in = {{swco_pkg::STEP_W{1'b0}}, cfg.stp_c}
            * {{swco_pkg::DIM_W{1'b0}}, cfg.step_x};
      wy_in = {{swco_pkg::STEP_W{1'b0}}, cfg.stp_r}
            * {{swco_pkg::DIM_W{1'b0}}, cfg.step_y};
   end

   always_comb begin
      classify(zx_ff, wx_ff, kx, xa, xb);
      classify(zy_ff, wy_ff, ky, ya, yb);
      num_in         = {yb, ya, xb, xa};
      side_in.kind_x = kx;
      side_in.kind_y = ky;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zx_ff   <= zx_in;
         zy_ff   <= zy_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         num_ff  <= num_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign num       = num_ff;
   assign side      = side_ff;

endmodule
`default_nettype wire

@@ sv/swco_div.sv @@
// ----------------------------------------------------------------------------
// swco_div: pipelined restoring divider, four lanes
// One quotient bit per stage; quotients that do not fit saturate to all ones.
// ----------------------------------------------------------------------------
`default_nettype none
module swco_div (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       adv,
   input  wire logic                                       in_valid,
   input  wire logic [swco_pkg::LANES-1:0][swco_pkg::NUM_W-1:0] num,
   input  wire swco_pkg::side_type                          in_side,
   input  wire logic [swco_pkg::STEP_W-1:0]                step_x,
   input  wire logic [swco_pkg::STEP_W-1:0]                step_y,
   output logic                                            out_valid,
   output logic [swco_pkg::LANES-1:0][swco_pkg::Q_W-1:0]   quo,
   output swco_pkg::side_type                              out_side
);

   localparam int QN = swco_pkg::Q_W;
   localparam int LN = swco_pkg::LANES;

   logic [QN-1:0][LN-1:0][swco_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [QN-1:0][LN-1:0][QN-1:0]              quo_ff, quo_in;
   logic [QN-1:0]                              vld_ff;
   swco_pkg::side_type                         side_ff [QN];
   logic [swco_pkg::DIV_W-1:0]                 dvs [LN];

   assign dvs[0] = {step_x, 1'b0};
   assign dvs[1] = {step_x, 1'b0};
   assign dvs[2] = {step_y, 1'b0};
   assign dvs[3] = {step_y, 1'b0};

   for (genvar s = 0; s < QN; s++) begin : g_stage
      localparam int B = QN - 1 - s;
      for (genvar l = 0; l < LN; l++) begin : g_lane
         logic [swco_pkg::NUM_W-1:0] rp;
         logic [QN-1:0]              qp;
         logic [swco_pkg::CMP_W-1:0] trial;
         logic [swco_pkg::CMP_W-1:0] lim;
         always_comb begin
            lim = swco_pkg::CMP_W'(dvs[l]) << QN;
            if (s == 0) begin
               if ({1'b0, num[l]} >= lim) begin
                  rp = '0;
                  qp = '1;
               end else begin
                  rp = num[l];
                  qp = '0;
               end
            end else begin
               rp = rem_ff[(s == 0) ? 0 : s-1][l];
               qp = quo_ff[(s == 0) ? 0 : s-1][l];
            end
            trial = {1'b0, rp} - (swco_pkg::CMP_W'(dvs[l]) << B);
            if (!trial[swco_pkg::CMP_W-1]) begin
               rem_in[s][l]    = trial[swco_pkg::NUM_W-1:0];
               quo_in[s][l]    = qp;
               quo_in[s][l][B] = 1'b1;
            end else begin
               rem_in[s][l] = rp;
               quo_in[s][l] = qp;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = vld_ff[QN-1];
   assign quo       = quo_ff[QN-1];
   assign out_side  = side_ff[QN-1];

endmodule
`default_nettype wire

@@ sv/swco_post.sv @@
// ----------------------------------------------------------------------------
// swco_post: overlap counts and linear offsets
// Turns the quotients into per-axis indices and counts, then forms the
// row-major start offsets into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module swco_post (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     adv,
   input  wire logic                                     in_valid,
   input  wire logic [swco_pkg::LANES-1:0][swco_pkg::Q_W-1:0] quo,
   input  wire swco_pkg::side_type                        side,
   input  wire swco_pkg::cfg_type                         cfg,
   output logic                                          out_valid,
   output swco_pkg::res_type                             res
);

   localparam int DW = swco_pkg::DIM_W;

   typedef struct packed {
      logic [DW-1:0] img_idx;
      logic [DW-1:0] st_idx;
      logic [DW-1:0] cnt;
   } axis_type;

   logic               va_ff, vb_ff;
   axis_type           ax_ff, ax_in, ay_ff, ay_in;
   logic               zero_ff, zero_in;
   swco_pkg::res_type  res_ff, res_in;
   logic [2*DW-1:0]    prod_i, prod_s;
   logic               both;

   function automatic axis_type axis_calc(
      input swco_pkg::kind_type kind,
      input logic               both_in,
      input logic [DW-1:0]      qa,
      input logic [DW-1:0]      qb,
      input logic [DW-1:0]      nstamp,
      input logic [DW-1:0]      nimg
   );
      axis_type  a;
      logic [DW:0] n;
      a = '0;
      if (kind == swco_pkg::KIND_INSIDE) begin
         a.st_idx = qa;
         if (both_in) begin
            n = {1'b0, qb};
         end else if (qa > nstamp) begin
            n = '0;
         end else begin
            n = {1'b0, nstamp} - {1'b0, qa};
         end
         if (n > {1'b0, nimg}) begin
            n = {1'b0, nimg};
         end
      end else begin
         a.img_idx = qa;
         if (qa >= nimg) begin
            n = '0;
         end else begin
            n = {1'b0, nimg} - {1'b0, qa};
            if (n > {1'b0, nstamp}) begin
               n = {1'b0, nstamp};
            end
         end
      end
      a.cnt = n[DW-1:0];
      return a;
   endfunction

   always_comb begin
      both    = (side.kind_x == swco_pkg::KIND_INSIDE)
             && (side.kind_y == swco_pkg::KIND_INSIDE);
      ax_in   = axis_calc(side.kind_x, both, quo[0], quo[1], cfg.stp_c, cfg.img_c);
      ay_in   = axis_calc(side.kind_y, both, quo[2], quo[3], cfg.stp_r, cfg.img_r);
      zero_in = (side.kind_x == swco_pkg::KIND_NONE)
             || (side.kind_y == swco_pkg::KIND_NONE)
             || (ax_in.cnt == '0) || (ay_in.cnt == '0);
   end

   always_comb begin
      prod_i = {{DW{1'b0}}, ay_ff.img_idx} * {{DW{1'b0}}, cfg.img_c};
      prod_s = {{DW{1'b0}}, ay_ff.st_idx} * {{DW{1'b0}}, cfg.stp_c};
      if (zero_ff) begin
         res_in = '0;
      end else begin
         res_in.image_offset = swco_pkg::OFS_W'(prod_i + (2*DW)'(ax_ff.img_idx));
         res_in.stamp_offset = swco_pkg::OFS_W'(prod_s + (2*DW)'(ax_ff.st_idx));
         res_in.overlap_cols = ax_ff.cnt;
         res_in.overlap_rows = ay_ff.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         zero_ff <= zero_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = vb_ff;
   assign res       = res_ff;

endmodule
`default_nettype wire
